// File: rtl/core/bnep_control_message_parser_assert.svh
// Assertion macros for the BNEP control message parser checker.
// Each expects clk and arst_n in the scope where it is used.
`ifndef BNEP_CONTROL_MESSAGE_PARSER_ASSERT_SVH
`define BNEP_CONTROL_MESSAGE_PARSER_ASSERT_SVH

// Same-cycle implication.
`define BNEP_ASSERT_NOW(lbl, pre, post) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (pre) |-> (post)) \
		else $error("bnep assertion failed");

// Next-cycle implication.
`define BNEP_ASSERT_NEXT(lbl, pre, post) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (pre) |=> (post)) \
		else $error("bnep assertion failed");

`endif

// File: rtl/core/bnep_pkg.sv
`timescale 1ns / 1ps
package bnep_pkg;

	localparam logic [7:0] TYPE_NOT_UNDERSTOOD = 8'h00;
	localparam logic [7:0] TYPE_SETUP_REQ      = 8'h01;
	localparam logic [7:0] TYPE_SETUP_RSP      = 8'h02;
	localparam logic [7:0] TYPE_NET_SET        = 8'h03;
	localparam logic [7:0] TYPE_NET_RSP        = 8'h04;
	localparam logic [7:0] TYPE_MULTI_SET      = 8'h05;
	localparam logic [7:0] TYPE_MULTI_RSP      = 8'h06;

	localparam logic [15:0] RSP_SUCCESS = 16'h0000;

	localparam logic [1:0] ST_OK        = 2'd0;
	localparam logic [1:0] ST_TRUNC     = 2'd1;
	localparam logic [1:0] ST_BAD_SIZE  = 2'd2;
	localparam logic [1:0] ST_UNKNOWN   = 2'd3;

	localparam logic [7:0] UUID_SIZE_2  = 8'd2;
	localparam logic [7:0] UUID_SIZE_4  = 8'd4;
	localparam logic [7:0] UUID_SIZE_16 = 8'd16;

	localparam logic [5:0] MAX_USED_BYTES = 6'd34;
	localparam logic [5:0] COUNT_MAX      = 6'd63;

	typedef struct packed {
		logic [5:0]  count;
		logic [7:0]  ctl_type;
		logic [7:0]  size;
		logic [15:0] field_a;
		logic [15:0] field_b;
	} bnep_state_t;

	typedef struct packed {
		logic [1:0]  status;
		logic [7:0]  ctl_type;
		logic [7:0]  unk_type;
		logic [4:0]  uuid_len;
		logic [15:0] dst_uuid;
		logic [15:0] src_uuid;
		logic [15:0] resp_code;
		logic        succ_flag;
	} bnep_result_t;

	function automatic logic size_ok(input logic [7:0] s);
		return (s == UUID_SIZE_2) || (s == UUID_SIZE_4) || (s == UUID_SIZE_16);
	endfunction

	function automatic logic is_rsp_type(input logic [7:0] t);
		return (t == TYPE_SETUP_RSP) || (t == TYPE_NET_RSP) || (t == TYPE_MULTI_RSP);
	endfunction

endpackage

// File: rtl/core/bnep_ifs.sv
`timescale 1ns / 1ps
interface bnep_in_if;
	logic       valid;
	logic       ready;
	logic [7:0] data_byte;
	logic       last_byte;

	modport source (output valid, output data_byte, output last_byte, input ready);
	modport sink (input valid, input data_byte, input last_byte, output ready);
endinterface

interface bnep_out_if;
	logic        valid;
	logic        ready;
	logic [1:0]  status;
	logic [7:0]  ctl_type;
	logic [7:0]  unk_type;
	logic [4:0]  uuid_len;
	logic [15:0] dst_uuid;
	logic [15:0] src_uuid;
	logic [15:0] resp_code;
	logic        succ_flag;

	modport source (
		output valid, output status, output ctl_type, output unk_type,
		output uuid_len, output dst_uuid, output src_uuid, output resp_code,
		output succ_flag, input ready
	);
	modport sink (
		input valid, input status, input ctl_type, input unk_type,
		input uuid_len, input dst_uuid, input src_uuid, input resp_code,
		input succ_flag, output ready
	);
endinterface

// File: rtl/core/bnep_capture.sv
`timescale 1ns / 1ps
module bnep_capture (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                adv,
	input  logic [7:0]          data_byte,
	input  logic                last_byte,
	output bnep_pkg::bnep_state_t cap
);
	import bnep_pkg::*;

	bnep_state_t state_q;
	bnep_state_t nxt;
	logic [5:0]  pos;
	logic [5:0]  dhi;
	logic [5:0]  shi;

	assign pos = state_q.count;

	always_comb begin
		dhi = (state_q.size == UUID_SIZE_2) ? 6'd2 : 6'd4;
		if (state_q.size == UUID_SIZE_2) begin
			shi = 6'd4;
		end else if (state_q.size == UUID_SIZE_4) begin
			shi = 6'd8;
		end else begin
			shi = 6'd20;
		end
	end

	always_comb begin
		cap = state_q;
		if (pos < MAX_USED_BYTES) begin
			if (pos == 6'd0) begin
				cap.ctl_type = data_byte;
			end else if (pos == 6'd1) begin
				cap.size = data_byte;
				if (is_rsp_type(state_q.ctl_type)) begin
					cap.field_a = {data_byte, 8'h00};
				end
			end else if (pos == 6'd2 && is_rsp_type(state_q.ctl_type)) begin
				cap.field_a = state_q.field_a | {8'h00, data_byte};
			end else if (state_q.ctl_type == TYPE_SETUP_REQ && size_ok(state_q.size)) begin
				if (pos == dhi) begin
					cap.field_a = {data_byte, 8'h00};
				end
				if (pos == dhi + 6'd1) begin
					cap.field_a = state_q.field_a | {8'h00, data_byte};
				end
				if (pos == shi) begin
					cap.field_b = {data_byte, 8'h00};
				end
				if (pos == shi + 6'd1) begin
					cap.field_b = state_q.field_b | {8'h00, data_byte};
				end
			end
		end
	end

	always_comb begin
		nxt       = cap;
		nxt.count = (pos < COUNT_MAX) ? pos + 6'd1 : pos;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= '0;
		end else if (adv) begin
			if (last_byte) begin
				state_q <= '0;
			end else begin
				state_q <= nxt;
			end
		end
	end

endmodule

// File: rtl/core/bnep_decode.sv
`timescale 1ns / 1ps
module bnep_decode (
	input  bnep_pkg::bnep_state_t  cap,
	output bnep_pkg::bnep_result_t res
);
	import bnep_pkg::*;

	logic [6:0] len;
	logic [6:0] need;

	assign len  = {1'b0, cap.count} + 7'd1;
	assign need = {cap.size[5:0], 1'b0} + 7'd2;

	always_comb begin
		res          = '0;
		res.status   = ST_OK;
		res.ctl_type = cap.ctl_type;
		case (cap.ctl_type)
			TYPE_NOT_UNDERSTOOD: begin
				if (len < 7'd2) begin
					res.status = ST_TRUNC;
				end else begin
					res.unk_type = cap.size;
				end
			end
			TYPE_SETUP_REQ: begin
				if (len < 7'd2) begin
					res.status = ST_TRUNC;
				end else if (!size_ok(cap.size)) begin
					res.status = ST_BAD_SIZE;
				end else if (len < need) begin
					res.status = ST_TRUNC;
				end else begin
					res.uuid_len = cap.size[4:0];
					res.dst_uuid = cap.field_a;
					res.src_uuid = cap.field_b;
				end
			end
			TYPE_SETUP_RSP, TYPE_NET_RSP, TYPE_MULTI_RSP: begin
				if (len < 7'd3) begin
					res.status = ST_TRUNC;
				end else begin
					res.resp_code = cap.field_a;
					res.succ_flag = (cap.ctl_type == TYPE_SETUP_RSP) &&
						(cap.field_a == RSP_SUCCESS);
				end
			end
			TYPE_NET_SET, TYPE_MULTI_SET: begin
				res.status = ST_OK;
			end
			default: begin
				res.status = ST_UNKNOWN;
			end
		endcase
	end

endmodule

// File: rtl/core/bnep_control_message_parser.sv
// BNEP control message parser: one message byte per item, one result per message.
// The final byte is taken into the input register, then its result into the result
// register once that is free. Throughput: one byte per cycle, but a final byte stalls
// while an unread result is held; the result register lets the next message start
// while a result still waits. Reset clears the byte counter, captured fields and valids.
`timescale 1ns / 1ps
module bnep_control_message_parser (
	input  logic              clk,
	input  logic              arst_n,
	bnep_in_if.sink           msg_in,
	bnep_out_if.source        res_out
);
	import bnep_pkg::*;

	logic         valid_s1;
	logic [7:0]   data_s1;
	logic         last_s1;
	logic         out_free;
	logic         adv_s1;
	logic         out_valid_q;
	bnep_state_t  cap;
	bnep_result_t res;
	bnep_result_t res_q;

	assign out_free     = !out_valid_q || res_out.ready;
	assign adv_s1       = valid_s1 && (!last_s1 || out_free);
	assign msg_in.ready = !valid_s1 || adv_s1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (msg_in.ready) begin
			valid_s1 <= msg_in.valid;
		end
	end

	always_ff @(posedge clk) begin
		if (msg_in.ready && msg_in.valid) begin
			data_s1 <= msg_in.data_byte;
			last_s1 <= msg_in.last_byte;
		end
	end

	bnep_capture u_capture (
		.clk       (clk),
		.arst_n    (arst_n),
		.adv       (adv_s1),
		.data_byte (data_s1),
		.last_byte (last_s1),
		.cap       (cap)
	);

	bnep_decode u_decode (
		.cap (cap),
		.res (res)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (adv_s1 && last_s1) begin
			out_valid_q <= 1'b1;
		end else if (res_out.ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (adv_s1 && last_s1) begin
			res_q <= res;
		end
	end

	assign res_out.valid     = out_valid_q;
	assign res_out.status    = res_q.status;
	assign res_out.ctl_type  = res_q.ctl_type;
	assign res_out.unk_type  = res_q.unk_type;
	assign res_out.uuid_len  = res_q.uuid_len;
	assign res_out.dst_uuid  = res_q.dst_uuid;
	assign res_out.src_uuid  = res_q.src_uuid;
	assign res_out.resp_code = res_q.resp_code;
	assign res_out.succ_flag = res_q.succ_flag;

endmodule

// File: rtl/core/bnep_chk.sv
`timescale 1ns / 1ps
`include "bnep_control_message_parser_assert.svh"
module bnep_chk (
	input logic        clk,
	input logic        arst_n,
	input logic        out_valid,
	input logic        out_ready,
	input logic [1:0]  status,
	input logic [7:0]  ctl_type,
	input logic [7:0]  unk_type,
	input logic [4:0]  uuid_len,
	input logic [15:0] dst_uuid,
	input logic [15:0] src_uuid,
	input logic [15:0] resp_code,
	input logic        succ_flag
);
	import bnep_pkg::*;

	`BNEP_ASSERT_NEXT(a_out_hold, out_valid && !out_ready, out_valid)
	`BNEP_ASSERT_NOW(a_err_no_fields, out_valid && status != ST_OK,
		unk_type == 8'h00 && uuid_len == 5'd0 && dst_uuid == 16'h0000 &&
		src_uuid == 16'h0000 && resp_code == 16'h0000 && !succ_flag)
	`BNEP_ASSERT_NOW(a_success_rsp, out_valid && succ_flag,
		ctl_type == TYPE_SETUP_RSP && resp_code == RSP_SUCCESS && status == ST_OK)
	`BNEP_ASSERT_NOW(a_uuid_len, out_valid && uuid_len != 5'd0,
		ctl_type == TYPE_SETUP_REQ && (uuid_len == 5'd2 || uuid_len == 5'd4 ||
		uuid_len == 5'd16))

endmodule

bind bnep_control_message_parser bnep_chk u_bnep_chk (
	.clk       (clk),
	.arst_n    (arst_n),
	.out_valid (res_out.valid),
	.out_ready (res_out.ready),
	.status    (res_out.status),
	.ctl_type  (res_out.ctl_type),
	.unk_type  (res_out.unk_type),
	.uuid_len  (res_out.uuid_len),
	.dst_uuid  (res_out.dst_uuid),
	.src_uuid  (res_out.src_uuid),
	.resp_code (res_out.resp_code),
	.succ_flag (res_out.succ_flag)
);

// File: tb/bnep_parse_checker.sv
`timescale 1ns / 1ps
module bnep_parse_checker (
	input  logic clk,
	input  logic arst_n,
	bnep_in_if   msg_in,
	bnep_out_if  res_out,
	output int   mismatches,
	output int   outstanding
);
	import bnep_pkg::*;

	logic [5:0]   n_seen;
	logic [7:0]   cur_type;
	logic [7:0]   cur_size;
	logic [15:0]  acc_a;
	logic [15:0]  acc_b;
	bnep_result_t pending_results[$];
	int           n_bad = 0;

	task automatic clear_parse_state();
		n_seen   = '0;
		cur_type = '0;
		cur_size = '0;
		acc_a    = '0;
		acc_b    = '0;
	endtask

	task automatic parse_byte(input logic [7:0] b, input logic lst);
		logic [5:0]   pos;
		logic [5:0]   d_at;
		logic [5:0]   s_at;
		int           len;
		bnep_result_t r;
		pos = n_seen;
		if (pos < MAX_USED_BYTES) begin
			if (pos == 6'd0) begin
				cur_type = b;
			end else if (pos == 6'd1) begin
				cur_size = b;
				if (cur_type inside {TYPE_SETUP_RSP, TYPE_NET_RSP, TYPE_MULTI_RSP})
					acc_a = {b, 8'h00};
			end else if (pos == 6'd2 &&
				cur_type inside {TYPE_SETUP_RSP, TYPE_NET_RSP, TYPE_MULTI_RSP}) begin
				acc_a = acc_a | {8'h00, b};
			end else if (cur_type == TYPE_SETUP_REQ &&
				cur_size inside {UUID_SIZE_2, UUID_SIZE_4, UUID_SIZE_16}) begin
				d_at = (cur_size == UUID_SIZE_2) ? 6'd2 : 6'd4;
				s_at = (cur_size == UUID_SIZE_2) ? 6'd4 :
					(cur_size == UUID_SIZE_4) ? 6'd8 : 6'd20;
				if (pos == d_at) acc_a = {b, 8'h00};
				if (pos == d_at + 6'd1) acc_a = acc_a | {8'h00, b};
				if (pos == s_at) acc_b = {b, 8'h00};
				if (pos == s_at + 6'd1) acc_b = acc_b | {8'h00, b};
			end
		end
		if (!lst) begin
			if (n_seen != COUNT_MAX) n_seen = n_seen + 6'd1;
			return;
		end
		len = int'(pos) + 1;
		r = '0;
		r.ctl_type = cur_type;
		case (cur_type)
			TYPE_NOT_UNDERSTOOD: begin
				if (len < 2) r.status = ST_TRUNC;
				else r.unk_type = cur_size;
			end
			TYPE_SETUP_REQ: begin
				if (len < 2) r.status = ST_TRUNC;
				else if (!(cur_size inside {UUID_SIZE_2, UUID_SIZE_4, UUID_SIZE_16}))
					r.status = ST_BAD_SIZE;
				else if (len < 2 + 2 * int'(cur_size)) r.status = ST_TRUNC;
				else begin
					r.uuid_len = cur_size[4:0];
					r.dst_uuid = acc_a;
					r.src_uuid = acc_b;
				end
			end
			TYPE_SETUP_RSP, TYPE_NET_RSP, TYPE_MULTI_RSP: begin
				if (len < 3) r.status = ST_TRUNC;
				else begin
					r.resp_code = acc_a;
					if (cur_type == TYPE_SETUP_RSP && acc_a == RSP_SUCCESS)
						r.succ_flag = 1'b1;
				end
			end
			TYPE_NET_SET, TYPE_MULTI_SET: r.status = ST_OK;
			default: r.status = ST_UNKNOWN;
		endcase
		pending_results.push_back(r);
		clear_parse_state();
	endtask

	always @(posedge clk or negedge arst_n) begin
		bnep_result_t got;
		bnep_result_t want;
		if (!arst_n) begin
			clear_parse_state();
			pending_results.delete();
		end else begin
			if (msg_in.valid && msg_in.ready)
				parse_byte(msg_in.data_byte, msg_in.last_byte);
			if (res_out.valid && res_out.ready) begin
				got.status    = res_out.status;
				got.ctl_type  = res_out.ctl_type;
				got.unk_type  = res_out.unk_type;
				got.uuid_len  = res_out.uuid_len;
				got.dst_uuid  = res_out.dst_uuid;
				got.src_uuid  = res_out.src_uuid;
				got.resp_code = res_out.resp_code;
				got.succ_flag = res_out.succ_flag;
				if (pending_results.size() == 0) begin
					n_bad++;
					if (n_bad <= 20)
						$display("%0t: unexpected result, expected none, actual %h",
							$time, got);
				end else begin
					want = pending_results.pop_front();
					if (got !== want) begin
						n_bad++;
						if (n_bad <= 20) begin
							$display({"%0t: mismatch expected st=%0d type=%h unk=%h ",
								"size=%0d dst=%h src=%h rsp=%h succ=%0d"}, $time,
								want.status, want.ctl_type, want.unk_type,
								want.uuid_len, want.dst_uuid, want.src_uuid,
								want.resp_code, want.succ_flag);
							$display({"%0t: mismatch actual   st=%0d type=%h unk=%h ",
								"size=%0d dst=%h src=%h rsp=%h succ=%0d"}, $time,
								got.status, got.ctl_type, got.unk_type,
								got.uuid_len, got.dst_uuid, got.src_uuid,
								got.resp_code, got.succ_flag);
						end
					end
				end
			end
		end
		mismatches  <= n_bad;
		outstanding <= pending_results.size();
	end

endmodule

// File: tb/tb_bnep_control_message_parser.sv
`timescale 1ns / 1ps
module tb_bnep_control_message_parser;
	import bnep_pkg::*;

	localparam int BYTE_TARGET = 1950;
	localparam int IDLE_LIMIT  = 5000;

	logic       clk;
	logic       arst_n;
	int         errors;
	int         pending;
	int         sent_bytes = 0;
	bit         fast = 0;
	logic [7:0] msg_buf[$];

	bnep_in_if  msg_in();
	bnep_out_if res_out();

	bnep_control_message_parser u_top (
		.clk    (clk),
		.arst_n (arst_n),
		.msg_in (msg_in),
		.res_out(res_out)
	);

	bnep_parse_checker u_chk (
		.clk        (clk),
		.arst_n     (arst_n),
		.msg_in     (msg_in),
		.res_out    (res_out),
		.mismatches (errors),
		.outstanding(pending)
	);

	initial begin
		clk = 1'b0;
		forever #2 clk = ~clk;
	end

	initial begin
		arst_n <= 1'b0;
		repeat (12) @(posedge clk);
		arst_n <= 1'b1;
	end

	function automatic int pick_gap();
		int r;
		r = $urandom_range(0, 99);
		if (r < 60) return 0;
		if (r < 95) return $urandom_range(1, 3);
		return $urandom_range(8, 40);
	endfunction

	task automatic send_buf();
		int gap;
		int i;
		for (i = 0; i < msg_buf.size(); i++) begin
			msg_in.valid     <= 1'b1;
			msg_in.data_byte <= msg_buf[i];
			msg_in.last_byte <= (i == msg_buf.size() - 1);
			@(posedge clk);
			while (!msg_in.ready) @(posedge clk);
			sent_bytes++;
			gap = fast ? 0 : pick_gap();
			if (gap > 0) begin
				msg_in.valid <= 1'b0;
				repeat (gap) @(posedge clk);
			end
		end
	endtask

	task automatic drain();
		msg_in.valid <= 1'b0;
		do @(posedge clk); while (pending != 0);
	endtask

	task automatic random_msg();
		int          kind;
		int          len;
		int          full;
		int          i;
		logic [7:0]  t;
		logic [7:0]  b1;
		logic [7:0]  b2;
		kind = $urandom_range(0, 99);
		b1 = 8'($urandom_range(0, 255));
		b2 = 8'($urandom_range(0, 255));
		if (kind < 30) begin
			t = TYPE_SETUP_REQ;
			case ($urandom_range(0, 9))
				0, 1, 2: b1 = UUID_SIZE_2;
				3, 4, 5: b1 = UUID_SIZE_4;
				6, 7, 8: b1 = UUID_SIZE_16;
				default: ;
			endcase
			if (b1 inside {UUID_SIZE_2, UUID_SIZE_4, UUID_SIZE_16}) begin
				full = 2 + 2 * int'(b1);
				case ($urandom_range(0, 9))
					0, 1: len = $urandom_range(1, full - 1);
					2: len = full + $urandom_range(1, 4);
					default: len = full;
				endcase
			end else begin
				len = $urandom_range(1, 6);
			end
		end else if (kind < 55) begin
			case ($urandom_range(0, 2))
				0: t = TYPE_SETUP_RSP;
				1: t = TYPE_NET_RSP;
				default: t = TYPE_MULTI_RSP;
			endcase
			if ($urandom_range(0, 2) == 0) {b1, b2} = RSP_SUCCESS;
			case ($urandom_range(0, 9))
				0, 1: len = $urandom_range(1, 2);
				2: len = $urandom_range(4, 7);
				default: len = 3;
			endcase
		end else if (kind < 65) begin
			t = TYPE_NOT_UNDERSTOOD;
			len = ($urandom_range(0, 4) == 0) ? $urandom_range(1, 4) : 2;
		end else if (kind < 80) begin
			t = ($urandom_range(0, 1) == 0) ? TYPE_NET_SET : TYPE_MULTI_SET;
			len = ($urandom_range(0, 9) == 0) ? $urandom_range(13, 40) : $urandom_range(1, 12);
		end else if (kind < 93) begin
			t = 8'($urandom_range(int'(TYPE_MULTI_RSP) + 1, 255));
			len = $urandom_range(1, 4);
		end else begin
			t = ($urandom_range(0, 3) == 0) ? 8'($urandom_range(0, 255)) :
				8'($urandom_range(int'(TYPE_NOT_UNDERSTOOD), int'(TYPE_MULTI_RSP)));
			if (t == TYPE_SETUP_REQ && $urandom_range(0, 1) == 0) b1 = UUID_SIZE_16;
			len = $urandom_range(35, 80);
		end
		msg_buf.delete();
		for (i = 0; i < len; i++) msg_buf.push_back(8'($urandom_range(0, 255)));
		msg_buf[0] = t;
		if (len > 1) msg_buf[1] = b1;
		if (len > 2) msg_buf[2] = b2;
	endtask

	initial begin
		bit paused;
		paused = 0;
		msg_in.valid     <= 1'b0;
		msg_in.data_byte <= '0;
		msg_in.last_byte <= 1'b0;
		wait (arst_n === 1'b1);
		@(posedge clk);

		msg_buf = {TYPE_NOT_UNDERSTOOD};
		send_buf();
		msg_buf = {TYPE_NOT_UNDERSTOOD, 8'hFF};
		send_buf();
		msg_buf = {TYPE_SETUP_REQ, 8'h07};
		send_buf();
		msg_buf = {TYPE_SETUP_REQ};
		send_buf();
		msg_buf = {TYPE_SETUP_REQ, UUID_SIZE_2, 8'hAB, 8'hCD, 8'h12, 8'h34};
		send_buf();
		msg_buf = {TYPE_SETUP_RSP, RSP_SUCCESS[15:8], RSP_SUCCESS[7:0]};
		send_buf();
		msg_buf = {TYPE_NET_RSP, 8'hFF, 8'hFF};
		send_buf();
		msg_buf = {TYPE_MULTI_RSP, 8'h12};
		send_buf();
		msg_buf = {TYPE_NET_SET};
		send_buf();
		msg_buf = {TYPE_MULTI_SET, 8'hAA};
		send_buf();
		msg_buf = {8'hFF};
		send_buf();
		drain();

		while (sent_bytes < BYTE_TARGET) begin
			if (!paused && sent_bytes >= 1200) begin
				paused = 1;
				drain();
			end
			fast = ($urandom_range(0, 4) == 0);
			random_msg();
			send_buf();
		end
		drain();
		repeat (8) @(posedge clk);
		if (errors == 0 && pending == 0)
			$display("tb_bnep_control_message_parser passed");
		else
			$display("tb_bnep_control_message_parser failed");
		$finish;
	end

	initial begin
		int  mode;
		int  stall;
		int  tick;
		bit  held;
		mode  = 0;
		stall = 0;
		tick  = 0;
		held  = 0;
		res_out.ready <= 1'b0;
		wait (arst_n === 1'b1);
		forever begin
			@(posedge clk);
			tick++;
			if (tick % 128 == 0) mode = $urandom_range(0, 2);
			if (!held && sent_bytes >= 500) begin
				held = 1;
				res_out.ready <= 1'b0;
				repeat (300) @(posedge clk);
			end else if (stall > 0) begin
				stall--;
				res_out.ready <= 1'b0;
			end else begin
				case (mode)
					0: res_out.ready <= 1'b1;
					1: begin
						if ($urandom_range(0, 9) == 0) begin
							stall = $urandom_range(0, 2);
							res_out.ready <= 1'b0;
						end else begin
							res_out.ready <= 1'b1;
						end
					end
					default: begin
						if ($urandom_range(0, 19) == 0) begin
							stall = $urandom_range(10, 40);
							res_out.ready <= 1'b0;
						end else begin
							res_out.ready <= ($urandom_range(0, 2) == 0);
						end
					end
				endcase
			end
		end
	end

	initial begin
		int quiet;
		quiet = 0;
		wait (arst_n === 1'b1);
		while (quiet < IDLE_LIMIT) begin
			@(posedge clk);
			if ((msg_in.valid && msg_in.ready) || (res_out.valid && res_out.ready))
				quiet = 0;
			else
				quiet++;
		end
		$display("%0t: no handshake for %0d cycles", $time, quiet);
		$display("tb_bnep_control_message_parser failed");
		$finish;
	end

endmodule
